/* hw/rtl/pbo_pkg.sv */
`default_nettype none

package pbo_pkg;

  localparam int PHASE_W = 16;
  localparam int STEP_W  = 15;
  localparam int GAIN_W  = 16;
  localparam int OUT_W   = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ACC_W   = 18;
  localparam int STATE_W = 32;
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int WIDE_W  = 35;
  localparam int DIV_CNT_W = $clog2(STEP_W + 1);

  localparam logic [PHASE_W-1:0] HALF_PHASE = 16'h8000;
  localparam logic [PHASE_W:0]   ONE_PHASE  = 17'h10000;
  localparam logic [15:0]        Q15_ONE    = 16'h8000;
  localparam logic signed [ACC_W-1:0] ACC_ONE = 18'sd32768;
  localparam logic [CFG_DATA_W-1:0] DUTY_RESET = 16'd32768;
  localparam logic [CFG_DATA_W-1:0] LEAK_RESET = 16'd65372;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sh7FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 20'sh80000;

  typedef enum logic [1:0] {
    WAVE_SAW    = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_TRI    = 2'd2
  } wave_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE = 2'd0,
    CFG_DUTY = 2'd1,
    CFG_LEAK = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_GAIN,
    S_T1,
    S_T2,
    S_T3,
    S_T4,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] num;
    logic [STEP_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [STEP_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-OUT_W:0] top;
    top = v[WIDE_W-1:OUT_W-1];
    if (top == '0 || top == '1) begin
      return v[OUT_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return OUT_MIN;
    end else begin
      return OUT_MAX;
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pbo_in_if.sv */
`default_nettype none

interface pbo_in_if;
  import pbo_pkg::*;

  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] phase_now;
  logic [STEP_W-1:0]  phase_step;
  logic [GAIN_W-1:0]  gain;

  modport source (output valid, output phase_now, output phase_step, output gain,
                  input ready);
  modport sink (input valid, input phase_now, input phase_step, input gain,
                output ready);
endinterface

`default_nettype wire

/* hw/rtl/pbo_out_if.sv */
`default_nettype none

interface pbo_out_if;
  import pbo_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pbo_cfg_if.sv */
`default_nettype none

interface pbo_cfg_if;
  import pbo_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pbo_div.sv */
`default_nettype none

module pbo_div (
  input  logic               clk,
  input  logic               rst,
  input  pbo_pkg::div_req_t  req,
  output pbo_pkg::div_rsp_t  rsp
);
  import pbo_pkg::*;

  logic [STEP_W-1:0]    rem;
  logic [STEP_W-1:0]    den_r;
  logic [STEP_W-1:0]    quot;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [STEP_W:0]      shifted;
  logic [STEP_W:0]      diff;
  logic                 fits;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(STEP_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= req.num;
      den_r <= req.den;
    end else if (busy) begin
      rem  <= fits ? diff[STEP_W-1:0] : shifted[STEP_W-1:0];
      quot <= {quot[STEP_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    busy && den_r != '0 |-> rem < den_r)
    else $error("divider remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy && !done)
    else $error("divider started while busy");

endmodule

`default_nettype wire

/* hw/rtl/polyblep_oscillator_top.sv */
// polyblep_oscillator_top: one band-limited oscillator sample per request.
// request carries phase_now, phase_step and gain; result carries sample_out.
// cfg writes waveform_select (index 0), duty_cycle (1) and leak_coefficient (2);
// cfg is always ready; the user must write it only while no request is in
// flight, which the block does not enforce. A request is taken only when the
// engine is idle. Each polyBLEP edge runs a setup step, then a bit-serial
// division; the steps per request are:
//   sawtooth: one edge, then gain scaling, then done
//   square:   rising and falling edge, then gain scaling, then done
//   triangle: both edges, integrator, leak, DC blocker and gain steps, then done
//   unused waveform code: straight to done, result 0
// The divider sets the rate: one quotient bit per cycle, one division per edge.
// The result sits in an output register; a new request is taken while it waits.
// When the receiver stalls with the output register full, the engine holds its
// finished sample and takes no new request until the output register frees.
// Reset clears the triangle integrator and DC blocker, the handshakes and
// loads the register defaults: sawtooth, duty one half, leak 65372.
`default_nettype none

module polyblep_oscillator_top (
  input  logic  clk,
  input  logic  rst,
  pbo_in_if.sink    request,
  pbo_out_if.source result,
  pbo_cfg_if.sink   cfg
);
  import pbo_pkg::*;

  state_t state;
  state_t state_next;

  logic [1:0]            sel;
  logic [CFG_DATA_W-1:0] duty;
  logic [CFG_DATA_W-1:0] leak;

  logic [STATE_W-1:0] slope_sum;
  logic [STATE_W-1:0] prev_scaled_sum;
  logic [STATE_W-1:0] blocker_out;
  logic [STATE_W-1:0] leak_term;

  logic [PHASE_W-1:0]       p_r;
  logic [STEP_W-1:0]        inc_r;
  logic [GAIN_W-1:0]        g_r;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_init;
  logic signed [ACC_W-1:0]  acc_next;
  logic                     second;
  logic                     lo_r;
  logic                     hi_r;
  logic signed [OUT_W-1:0]  res;
  logic signed [OUT_W-1:0]  sample_r;
  logic                     out_valid;

  logic                     accept;
  logic                     load;
  logic                     wave_ok;
  logic [PHASE_W-1:0]       duty_eff;
  logic [PHASE_W-1:0]       pos;
  logic [PHASE_W:0]         wrap_gap;
  logic                     lo;
  logic                     hi;
  logic [15:0]              r;
  logic [15:0]              sq;
  logic signed [ACC_W-1:0]  bmag;
  logic signed [ACC_W-1:0]  bval;
  logic                     bsub;
  logic [STATE_W-1:0]       four;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  div_req_t div_req;
  div_rsp_t div_rsp;

  pbo_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg.ready     = 1'b1;
  assign request.ready = (state == S_IDLE);
  assign accept        = request.valid && request.ready;
  assign load          = (state == S_DONE) && (!out_valid || result.ready);
  assign result.valid      = out_valid;
  assign result.sample_out = sample_r;

  assign wave_ok  = (sel == WAVE_SAW) || (sel == WAVE_SQUARE) || (sel == WAVE_TRI);
  assign duty_eff = (sel == WAVE_TRI) ? HALF_PHASE : duty;

  // naive shape before corrections
  always_comb begin
    if (sel == WAVE_SAW) begin
      acc_init = $signed({2'b00, request.phase_now}) - ACC_ONE;
    end else if (request.phase_now < duty_eff) begin
      acc_init = ACC_ONE;
    end else begin
      acc_init = -ACC_ONE;
    end
  end

  // blep position: phase, then phase minus duty for the falling edge
  assign pos      = second ? (p_r - duty_eff) : p_r;
  assign wrap_gap = ONE_PHASE - {1'b0, pos};
  assign lo       = pos < {1'b0, inc_r};
  assign hi       = (pos != '0) && (wrap_gap < {2'b00, inc_r});

  assign r    = Q15_ONE - {1'b0, div_rsp.quot};
  assign sq   = mul_p[30:15];
  assign bmag = $signed({2'b00, sq});
  assign bval = lo_r ? -bmag : (hi_r ? bmag : '0);
  assign bsub = (sel == WAVE_SAW) || second;
  assign acc_next = bsub ? acc - bval : acc + bval;

  assign four  = {slope_sum[STATE_W-3:0], 2'b00};
  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_next    = state;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = inc_r;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state)
      S_IDLE: begin
        if (request.valid) begin
          state_next = wave_ok ? S_SETUP : S_DONE;
        end
      end
      S_SETUP: begin
        div_req.start = 1'b1;
        if (lo) begin
          div_req.num = pos[STEP_W-1:0];
        end else if (hi) begin
          div_req.num = wrap_gap[STEP_W-1:0];
        end
        state_next = S_DIV;
      end
      S_DIV: begin
        mul_a = $signed({17'b0, r});
        mul_b = $signed({1'b0, r});
        if (div_rsp.done) begin
          if (sel == WAVE_SAW) begin
            state_next = S_GAIN;
          end else if (!second) begin
            state_next = S_SETUP;
          end else if (sel == WAVE_TRI) begin
            state_next = S_T1;
          end else begin
            state_next = S_GAIN;
          end
        end
      end
      S_GAIN: begin
        mul_a = {{(MUL_A_W-ACC_W){acc[ACC_W-1]}}, acc};
        mul_b = $signed({1'b0, g_r});
        state_next = S_DONE;
      end
      S_T1: begin
        mul_a = {{(MUL_A_W-ACC_W){acc[ACC_W-1]}}, acc};
        mul_b = $signed({2'b00, inc_r});
        state_next = S_T2;
      end
      S_T2: begin
        mul_a = $signed({blocker_out[STATE_W-1], blocker_out});
        mul_b = $signed({1'b0, leak});
        state_next = S_T3;
      end
      S_T3: begin
        state_next = S_T4;
      end
      S_T4: begin
        mul_a = $signed({blocker_out[STATE_W-1], blocker_out});
        mul_b = $signed({1'b0, g_r});
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || result.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      sel             <= WAVE_SAW;
      duty            <= DUTY_RESET;
      leak            <= LEAK_RESET;
      slope_sum       <= '0;
      prev_scaled_sum <= '0;
      blocker_out     <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_WAVE: sel  <= cfg.data[1:0];
          CFG_DUTY: duty <= cfg.data;
          CFG_LEAK: leak <= cfg.data;
          default: ;
        endcase
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_T1) begin
        slope_sum <= slope_sum + mul_p[38:7];
      end
      if (state == S_T3) begin
        prev_scaled_sum <= four;
        blocker_out     <= four - prev_scaled_sum + leak_term;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_r    <= request.phase_now;
      inc_r  <= request.phase_step;
      g_r    <= request.gain;
      acc    <= acc_init;
      second <= 1'b0;
      res    <= '0;
    end
    if (state == S_SETUP) begin
      lo_r <= lo;
      hi_r <= hi;
    end
    if (state == S_DIV && div_rsp.done) begin
      acc    <= acc_next;
      second <= 1'b1;
    end
    if (state == S_GAIN) begin
      res <= sat_out(mul_p[MUL_P_W-1:15]);
    end
    if (state == S_T2) begin
      leak_term <= mul_p[47:16];
    end
    if (state == S_T4) begin
      res <= sat_out({{9{mul_p[MUL_P_W-1]}}, mul_p[MUL_P_W-1:24]});
    end
    if (load) begin
      sample_r <= res;
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("division finished outside the division state");

  a_blocker_only_tri: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(blocker_out) |-> $past(state) == S_T3)
    else $error("dc blocker changed outside its update");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && result.valid && !result.ready |=> state == S_DONE)
    else $error("finished sample dropped while output stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("engine idle right after taking a transaction");

endmodule

`default_nettype wire

/* sim/polyblep_oscillator_top_tb.sv */
`timescale 1ns / 100ps

import pbo_pkg::*;

class osc_scoreboard;
  logic [1:0]              wave_sel;
  logic [CFG_DATA_W-1:0]   duty;
  logic [CFG_DATA_W-1:0]   leak;
  logic [STATE_W-1:0]      integ;
  logic [STATE_W-1:0]      prev_four;
  logic [STATE_W-1:0]      dc_out;
  logic signed [OUT_W-1:0] expected_samples[$];
  int unsigned             errors;

  function new();
    wave_sel  = WAVE_SAW;
    duty      = DUTY_RESET;
    leak      = LEAK_RESET;
    integ     = '0;
    prev_four = '0;
    dc_out    = '0;
    errors    = 0;
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_WAVE: wave_sel = val[1:0];
      CFG_DUTY: duty = val;
      CFG_LEAK: leak = val;
      default: ;
    endcase
  endfunction

  // polyblep correction around the wrap of p
  function longint edge_residual(longint p, longint step);
    longint r;
    if (p < step) begin
      r = 32768 - (p * 32768) / step;
      return -((r * r) >>> 15);
    end
    if (p > 65536 - step) begin
      r = 32768 - ((65536 - p) * 32768) / step;
      return (r * r) >>> 15;
    end
    return 0;
  endfunction

  function longint pulse_wave(longint p, longint step, longint d);
    longint v;
    v = (p < d) ? 32768 : -32768;
    v += edge_residual(p, step);
    v -= edge_residual((p + 65536 - d) % 65536, step);
    return v;
  endfunction

  function logic signed [OUT_W-1:0] clip_sample(longint v);
    if (v > 524287) return 20'sh7FFFF;
    if (v < -524288) return 20'sh80000;
    return v[OUT_W-1:0];
  endfunction

  function void note_request(logic [PHASE_W-1:0] ph, logic [STEP_W-1:0] st,
                             logic [GAIN_W-1:0] gn);
    longint p, step, g, wave, slope, fb, acc;
    logic [STATE_W-1:0] four, y;
    p = longint'(ph);
    step = longint'(st);
    g = longint'(gn);
    acc = 0;
    case (wave_sel)
      WAVE_SAW: begin
        wave = p - 32768 - edge_residual(p, step);
        acc = (wave * g) >>> 15;
      end
      WAVE_SQUARE: begin
        acc = (pulse_wave(p, step, longint'(duty)) * g) >>> 15;
      end
      WAVE_TRI: begin
        slope = (pulse_wave(p, step, longint'(HALF_PHASE)) * step) >>> 7;
        integ = integ + slope[STATE_W-1:0];
        four = integ << 2;
        fb = (longint'($signed(dc_out)) * longint'(leak)) >>> 16;
        y = four - prev_four + fb[STATE_W-1:0];
        prev_four = four;
        dc_out = y;
        acc = (longint'($signed(y)) * g) >>> 24;
      end
      default: acc = 0;
    endcase
    expected_samples.push_back(clip_sample(acc));
  endfunction

  function void check_sample(logic signed [OUT_W-1:0] got);
    logic signed [OUT_W-1:0] exp_val;
    if (expected_samples.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected sample %0d", got);
      return;
    end
    exp_val = expected_samples.pop_front();
    if (got !== exp_val) begin
      errors++;
      if (errors <= 10) $display("sample mismatch: expected %0d, got %0d", exp_val, got);
    end
  endfunction

  function int unsigned outstanding();
    return expected_samples.size();
  endfunction
endclass

module polyblep_oscillator_top_tb;
  localparam logic [1:0]           WAVE_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned          ACCEPT_TIMEOUT = 5000;

  logic clk;
  logic rst;
  logic rx_ready = 1'b0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  osc_scoreboard sb = new();

  pbo_in_if  osc_req();
  pbo_out_if osc_res();
  pbo_cfg_if osc_cfg();

  assign osc_res.ready = rx_ready;

  polyblep_oscillator_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .request(osc_req),
    .result (osc_res),
    .cfg    (osc_cfg)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver back-pressure, mode re-drawn whenever its random hold count runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: rx_ready <= 1'b1;
      1: rx_ready <= 1'($urandom_range(0, 1));
      2: rx_ready <= ($urandom_range(0, 9) == 0);
      default: rx_ready <= (stall_left % 16) >= 5;
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (osc_cfg.valid && osc_cfg.ready) sb.write_register(osc_cfg.index, osc_cfg.data);
      if (osc_req.valid && osc_req.ready)
        sb.note_request(osc_req.phase_now, osc_req.phase_step, osc_req.gain);
      if (osc_res.valid && osc_res.ready) sb.check_sample(osc_res.sample_out);
    end
  end

  always @(posedge clk) begin
    if ((osc_cfg.valid && osc_cfg.ready) || (osc_req.valid && osc_req.ready) ||
        (osc_res.valid && osc_res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == ACCEPT_TIMEOUT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 4))
      0: return STEP_W'($urandom_range(1, 255));
      1: return STEP_W'($urandom_range(256, 4095));
      2: return STEP_W'($urandom_range(4096, 32767));
      3: return $urandom_range(0, 1) ? 15'h7FFF : 15'd0;
      default: return STEP_W'($urandom_range(1, 31));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'd32768;
      1: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic send_request(input logic [PHASE_W-1:0] ph, input logic [STEP_W-1:0] st,
                              input logic [GAIN_W-1:0] gn);
    osc_req.valid      <= 1'b1;
    osc_req.phase_now  <= ph;
    osc_req.phase_step <= st;
    osc_req.gain       <= gn;
    do @(posedge clk); while (!osc_req.ready);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      if ($urandom_range(0, 3) != 0) begin
        osc_req.valid <= 1'b0;
        repeat ($urandom_range(1, 45)) @(posedge clk);
      end
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    osc_cfg.valid <= 1'b1;
    osc_cfg.index <= idx;
    osc_cfg.data  <= val;
    do @(posedge clk); while (!osc_cfg.ready);
  endtask

  // upper bits of the waveform data are don't-care
  task automatic apply_settings(input logic [1:0] wave, input logic [CFG_DATA_W-1:0] duty,
                                input logic [CFG_DATA_W-1:0] leak, input bit spare);
    logic [13:0] junk;
    junk = 14'($urandom);
    if (spare) cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_write(CFG_WAVE, {junk, wave});
    cfg_write(CFG_DUTY, duty);
    cfg_write(CFG_LEAK, leak);
    osc_cfg.valid <= 1'b0;
  endtask

  task automatic settle();
    if (osc_req.valid) osc_req.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // mostly phase-accumulator runs, with stray requests mixed in
  task automatic run_random(input int unsigned count);
    logic [PHASE_W-1:0] ph;
    logic [STEP_W-1:0]  st;
    int unsigned run_len;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      st = pick_step();
      ph = PHASE_W'($urandom);
      run_len = $urandom_range(4, 64);
      for (int k = 0; k < run_len && sent < count; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          send_request(PHASE_W'($urandom), STEP_W'($urandom), pick_gain());
        end else begin
          send_request(ph, st, pick_gain());
          ph = ph + st;
        end
        sent++;
      end
    end
  endtask

  task automatic run_phase(input logic [1:0] wave, input logic [CFG_DATA_W-1:0] duty,
                           input logic [CFG_DATA_W-1:0] leak, input bit spare,
                           input int unsigned count);
    settle();
    apply_settings(wave, duty, leak, spare);
    run_random(count);
  endtask

  initial begin
    rst = 1'b1;
    osc_req.valid = 1'b0;
    osc_req.phase_now = '0;
    osc_req.phase_step = '0;
    osc_req.gain = '0;
    osc_cfg.valid = 1'b0;
    osc_cfg.index = '0;
    osc_cfg.data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // sawtooth at reset defaults
    send_request(16'd0, 15'd0, 16'd32768);
    send_request(16'hFFFF, 15'h7FFF, 16'hFFFF);
    send_request(16'd0, 15'h7FFF, 16'd32768);
    send_request(16'hFFFF, 15'd1, 16'd32768);
    send_request(16'd100, 15'd200, 16'd32768);
    send_request(16'd65500, 15'd100, 16'd0);
    send_request(16'd32768, 15'd16384, 16'd32768);
    send_request(16'd1234, 15'd0, 16'hFFFF);

    // square, both edges
    settle();
    apply_settings(WAVE_SQUARE, HALF_PHASE, LEAK_RESET, 1'b0);
    send_request(16'd32767, 15'd300, 16'd32768);
    send_request(16'd32800, 15'd300, 16'd32768);
    send_request(16'd0, 15'h7FFF, 16'hFFFF);
    send_request(16'hFFFF, 15'h7FFF, 16'd32768);
    send_request(16'd40000, 15'd0, 16'd32768);

    // narrow duty: falling edge residual uses phase minus duty
    settle();
    apply_settings(WAVE_SQUARE, 16'd1000, LEAK_RESET, 1'b0);
    send_request(16'd990, 15'd50, 16'd32768);
    send_request(16'd1010, 15'd50, 16'd32768);
    send_request(16'd65530, 15'd50, 16'd32768);

    // triangle ignores duty
    settle();
    apply_settings(WAVE_TRI, 16'd20000, LEAK_RESET, 1'b0);
    for (int i = 0; i < 6; i++) send_request(16'(i * 8000), 15'd8000, 16'd32768);

    // unused waveform code
    settle();
    apply_settings(WAVE_NONE, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'b1);
    send_request(16'd100, 15'd200, 16'd32768);
    send_request(16'hFFFF, 15'h7FFF, 16'hFFFF);

    run_phase(WAVE_SAW, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'b0, 150);
    run_phase(WAVE_SQUARE, HALF_PHASE, LEAK_RESET, 1'b0, 150);
    run_phase(WAVE_SQUARE, 16'd0, 16'd0, 1'b0, 100);
    run_phase(WAVE_SQUARE, 16'hFFFF, 16'hFFFF, 1'b0, 100);
    run_phase(WAVE_SQUARE, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'b0, 150);
    run_phase(WAVE_TRI, HALF_PHASE, LEAK_RESET, 1'b0, 250);
    run_phase(WAVE_TRI, CFG_DATA_W'($urandom), 16'd0, 1'b0, 100);
    run_phase(WAVE_TRI, CFG_DATA_W'($urandom), 16'hFFFF, 1'b0, 150);
    run_phase(WAVE_NONE, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'b1, 50);
    run_phase(WAVE_SAW, 16'hFFFF, 16'd0, 1'b0, 50);

    settle();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/pbo_pkg.sv
hw/rtl/pbo_in_if.sv
hw/rtl/pbo_out_if.sv
hw/rtl/pbo_cfg_if.sv
hw/rtl/pbo_div.sv
hw/rtl/polyblep_oscillator_top.sv
sim/polyblep_oscillator_top_tb.sv
